### hw/rtl/lsfe_pkg.sv
// Shared types, codes and helper functions of the LIN slave frame engine.
// Depends on nothing; every other file of the block but lsfe_ram imports it.
`timescale 1ns / 1ps
`default_nettype none

package lsfe_pkg;

   localparam int NUM_SLOTS_DEF = 4;
   localparam int MAX_LEN_DEF   = 8;
   localparam int SLOT_REGS     = 4;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 12;
   localparam int LEN_W         = 4;
   localparam logic [7:0] SYNC_BYTE = 8'h55;

   typedef enum logic [1:0] {
      KIND_BREAK   = 2'd0,
      KIND_BYTE    = 2'd1,
      KIND_HOST_WR = 2'd2,
      KIND_HOST_RD = 2'd3
   } lsfe_kind_type;

   typedef enum logic [3:0] {
      EV_TX       = 4'd0,
      EV_RXOK     = 4'd1,
      EV_READ     = 4'd2,
      EV_BREAK    = 4'd3,
      EV_SYNC     = 4'd4,
      EV_PARITY   = 4'd5,
      EV_UNKNOWN  = 4'd6,
      EV_CHECKSUM = 4'd7,
      EV_STRAY    = 4'd8
   } lsfe_event_type;

   typedef enum logic [2:0] {
      CSR_CHECKSUM_ENH = 3'd0,
      CSR_BREAK_SYNC   = 3'd1,
      CSR_SLOT_0       = 3'd2,
      CSR_SLOT_1       = 3'd3,
      CSR_SLOT_2       = 3'd4,
      CSR_SLOT_3       = 3'd5
   } lsfe_csr_type;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_SYNC = 2'd1,
      PH_PID  = 2'd2,
      PH_DATA = 2'd3
   } lsfe_phase_type;

   typedef enum logic [3:0] {
      ST_ACCEPT,
      ST_DECODE,
      ST_READ_WAIT,
      ST_TX_FETCH,
      ST_TX_SEND,
      ST_TX_CHECK,
      ST_CK_FETCH,
      ST_CK_ADD,
      ST_COPY_FETCH,
      ST_COPY_WRITE
   } lsfe_state_type;

   // Slot table entry, same packing as the register
   typedef struct packed {
      logic       enabled;
      logic       transmit;
      logic [3:0] len;
      logic [5:0] id;
   } lsfe_slot_entry_type;

   typedef struct packed {
      logic enhanced;
      logic break_is_sync;
   } lsfe_cfg_type;

   typedef struct packed {
      logic             found;
      logic [1:0]       slot;
      logic             transmit;
      logic [LEN_W-1:0] len;
   } lsfe_lookup_type;

   // Protected identifier: ID with its two parity bits on top
   function automatic logic [7:0] protect_id(input logic [5:0] id);
      logic p0;
      logic p1;
      p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
      p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
      return {p1, p0, id};
   endfunction

   // Add with end-around carry
   function automatic logic [7:0] oc_add(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s > 9'd255) s = s - 9'd255;
      return s[7:0];
   endfunction

endpackage

`default_nettype wire

### hw/rtl/lsfe_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// Holds the slot data store and the receive buffer. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lsfe_ram #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 8,
   parameter int AW    = 5
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             re,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
   end

   // Hold the read data until the next read
   always_ff @(posedge clock) begin
      if (re) rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### hw/rtl/lsfe_cfg.sv
// Configuration registers and slot table lookup of the LIN slave frame engine.
// Depends on lsfe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lsfe_cfg #(
   parameter int NUM_SLOTS = lsfe_pkg::NUM_SLOTS_DEF,
   parameter int MAX_LEN   = lsfe_pkg::MAX_LEN_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [lsfe_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [lsfe_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  wire logic [5:0]                          lookup_id,
   input  wire logic [1:0]                          cur_slot,
   output lsfe_pkg::lsfe_cfg_type                   cfg,
   output lsfe_pkg::lsfe_lookup_type                lookup,
   output logic [lsfe_pkg::LEN_W-1:0]               live_len
);
   import lsfe_pkg::*;

   logic                enh_ff, enh_in;
   logic                brk_sync_ff, brk_sync_in;
   lsfe_slot_entry_type slot_ff [SLOT_REGS];
   lsfe_slot_entry_type slot_in [SLOT_REGS];

   function automatic logic [LEN_W-1:0] sat_len(input logic [3:0] l);
      if (int'(l) > MAX_LEN) return LEN_W'(MAX_LEN);
      return l;
   endfunction

   always_comb begin
      enh_in      = enh_ff;
      brk_sync_in = brk_sync_ff;
      for (int s = 0; s < SLOT_REGS; s++) slot_in[s] = slot_ff[s];
      if (csr_we) begin
         unique case (csr_index)
            CSR_CHECKSUM_ENH: enh_in      = csr_wdata[0];
            CSR_BREAK_SYNC:   brk_sync_in = csr_wdata[0];
            CSR_SLOT_0:       slot_in[0]  = lsfe_slot_entry_type'(csr_wdata);
            CSR_SLOT_1:       slot_in[1]  = lsfe_slot_entry_type'(csr_wdata);
            CSR_SLOT_2:       slot_in[2]  = lsfe_slot_entry_type'(csr_wdata);
            CSR_SLOT_3:       slot_in[3]  = lsfe_slot_entry_type'(csr_wdata);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enh_ff      <= 1'b1;
         brk_sync_ff <= 1'b0;
         for (int s = 0; s < SLOT_REGS; s++) slot_ff[s] <= '0;
      end else begin
         enh_ff      <= enh_in;
         brk_sync_ff <= brk_sync_in;
         for (int s = 0; s < SLOT_REGS; s++) slot_ff[s] <= slot_in[s];
      end
   end

   assign cfg.enhanced      = enh_ff;
   assign cfg.break_is_sync = brk_sync_ff;
   assign live_len          = sat_len(slot_ff[cur_slot].len);

   // Lowest numbered enabled slot with a matching ID wins
   always_comb begin
      lookup = '0;
      for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
         if (slot_ff[s].enabled && slot_ff[s].id == lookup_id) begin
            lookup.found    = 1'b1;
            lookup.slot     = 2'(s);
            lookup.transmit = slot_ff[s].transmit;
            lookup.len      = sat_len(slot_ff[s].len);
         end
      end
   end

endmodule

`default_nettype wire

### hw/rtl/lsfe_ctrl.sv
// Frame sequencer of the LIN slave frame engine: header tracking, transmit
// bursts, checksum and copy passes over the two RAMs, result register.
// Depends on lsfe_pkg and lsfe_ram.
`timescale 1ns / 1ps
`default_nettype none

module lsfe_ctrl #(
   parameter int NUM_SLOTS = lsfe_pkg::NUM_SLOTS_DEF,
   parameter int MAX_LEN   = lsfe_pkg::MAX_LEN_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire lsfe_pkg::lsfe_kind_type   req_kind,
   input  wire logic [7:0]                req_data_byte,
   input  wire logic [1:0]                req_slot_index,
   input  wire logic [2:0]                req_byte_index,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output lsfe_pkg::lsfe_event_type       rsp_event,
   output logic [1:0]                     rsp_slot,
   output logic [7:0]                     rsp_byte,
   output logic                           rsp_last,
   input  wire lsfe_pkg::lsfe_cfg_type    cfg,
   input  wire lsfe_pkg::lsfe_lookup_type lookup,
   input  wire logic [lsfe_pkg::LEN_W-1:0] live_len,
   output logic [5:0]                     lookup_id,
   output logic [1:0]                     cur_slot
);
   import lsfe_pkg::*;

   localparam int ST_DEPTH = NUM_SLOTS * MAX_LEN;
   localparam int ST_AW    = (ST_DEPTH > 1) ? $clog2(ST_DEPTH) : 1;
   localparam int RB_AW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

   // control state
   lsfe_state_type   st_ff, st_in;
   lsfe_phase_type   phase_ff, phase_in;
   logic [LEN_W-1:0] byte_cnt_ff, byte_cnt_in;
   logic [LEN_W-1:0] idx_ff, idx_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [1:0]       cur_slot_ff, cur_slot_in;
   logic [7:0]       cur_pid_ff, cur_pid_in;
   logic [7:0]       sum_ff, sum_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // latched request and result payload
   lsfe_kind_type    kind_ff, kind_in;
   logic [7:0]       db_ff, db_in;
   logic [1:0]       si_ff, si_in;
   logic [2:0]       bi_ff, bi_in;
   lsfe_event_type   rsp_event_ff, rsp_event_in;
   logic [1:0]       rsp_slot_ff, rsp_slot_in;
   logic [7:0]       rsp_byte_ff, rsp_byte_in;
   logic             rsp_last_ff, rsp_last_in;

   // result request from the sequencer
   logic             emit;
   lsfe_event_type   ev;
   logic [1:0]       sl;
   logic [7:0]       ob;
   logic             lst;
   logic             out_free;
   logic             host_ok;

   // RAM ports
   logic             st_we, st_re;
   logic [ST_AW-1:0] st_waddr, st_raddr;
   logic [7:0]       st_wdata, st_rdata;
   logic             rb_we, rb_re;
   logic [RB_AW-1:0] rb_waddr, rb_raddr;
   logic [7:0]       rb_wdata, rb_rdata;

   function automatic logic [ST_AW-1:0] st_addr(input logic [1:0] s,
                                                input logic [LEN_W-1:0] i);
      return ST_AW'(ST_AW'(s) * ST_AW'(MAX_LEN) + ST_AW'(i));
   endfunction

   lsfe_ram #(.DEPTH(ST_DEPTH), .WIDTH(8), .AW(ST_AW)) u_store (
      .clock (clock),
      .we    (st_we),
      .waddr (st_waddr),
      .wdata (st_wdata),
      .re    (st_re),
      .raddr (st_raddr),
      .rdata (st_rdata)
   );

   lsfe_ram #(.DEPTH(MAX_LEN), .WIDTH(8), .AW(RB_AW)) u_rxbuf (
      .clock (clock),
      .we    (rb_we),
      .waddr (rb_waddr),
      .wdata (rb_wdata),
      .re    (rb_re),
      .raddr (rb_raddr),
      .rdata (rb_rdata)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign host_ok   = (int'(si_ff) < NUM_SLOTS) && (int'(bi_ff) < MAX_LEN);
   assign lookup_id = db_ff[5:0];
   assign cur_slot  = cur_slot_ff;

   always_comb begin
      st_in        = st_ff;
      phase_in     = phase_ff;
      byte_cnt_in  = byte_cnt_ff;
      idx_in       = idx_ff;
      len_in       = len_ff;
      cur_slot_in  = cur_slot_ff;
      cur_pid_in   = cur_pid_ff;
      sum_in       = sum_ff;
      kind_in      = kind_ff;
      db_in        = db_ff;
      si_in        = si_ff;
      bi_in        = bi_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_event_in = rsp_event_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      emit         = 1'b0;
      ev           = EV_TX;
      sl           = 2'd0;
      ob           = 8'd0;
      lst          = 1'b1;
      st_we        = 1'b0;
      st_waddr     = '0;
      st_wdata     = db_ff;
      st_re        = 1'b0;
      st_raddr     = '0;
      rb_we        = 1'b0;
      rb_waddr     = byte_cnt_ff[RB_AW-1:0];
      rb_wdata     = db_ff;
      rb_re        = 1'b0;
      rb_raddr     = idx_ff[RB_AW-1:0];
      req_ready    = (st_ff == ST_ACCEPT);

      unique case (st_ff)
         ST_ACCEPT: begin
            if (req_valid) begin
               kind_in = req_kind;
               db_in   = req_data_byte;
               si_in   = req_slot_index;
               bi_in   = req_byte_index;
               st_in   = ST_DECODE;
            end
         end

         ST_DECODE: begin
            unique case (kind_ff)
               KIND_BREAK: begin
                  if (phase_ff == PH_IDLE || out_free) begin
                     if (phase_ff != PH_IDLE) begin
                        emit = 1'b1;
                        ev   = EV_BREAK;
                        sl   = cur_slot_ff;
                     end
                     phase_in    = cfg.break_is_sync ? PH_PID : PH_SYNC;
                     byte_cnt_in = '0;
                     st_in       = ST_ACCEPT;
                  end
               end
               KIND_HOST_WR: begin
                  st_we    = host_ok;
                  st_waddr = st_addr(si_ff, LEN_W'(bi_ff));
                  st_in    = ST_ACCEPT;
               end
               KIND_HOST_RD: begin
                  if (host_ok) begin
                     st_re    = 1'b1;
                     st_raddr = st_addr(si_ff, LEN_W'(bi_ff));
                     st_in    = ST_READ_WAIT;
                  end else if (out_free) begin
                     emit  = 1'b1;
                     ev    = EV_READ;
                     sl    = si_ff;
                     st_in = ST_ACCEPT;
                  end
               end
               KIND_BYTE: begin
                  unique case (phase_ff)
                     PH_SYNC: begin
                        if (db_ff == SYNC_BYTE) begin
                           phase_in = PH_PID;
                           st_in    = ST_ACCEPT;
                        end else if (out_free) begin
                           emit        = 1'b1;
                           ev          = EV_SYNC;
                           phase_in    = PH_IDLE;
                           byte_cnt_in = '0;
                           st_in       = ST_ACCEPT;
                        end
                     end
                     PH_PID: begin
                        if (protect_id(db_ff[5:0]) != db_ff || !lookup.found) begin
                           if (out_free) begin
                              emit        = 1'b1;
                              ev          = (protect_id(db_ff[5:0]) != db_ff) ?
                                            EV_PARITY : EV_UNKNOWN;
                              phase_in    = PH_IDLE;
                              byte_cnt_in = '0;
                              st_in       = ST_ACCEPT;
                           end
                        end else begin
                           cur_slot_in = lookup.slot;
                           cur_pid_in  = db_ff;
                           byte_cnt_in = '0;
                           if (lookup.transmit) begin
                              phase_in = PH_IDLE;
                              len_in   = lookup.len;
                              idx_in   = '0;
                              sum_in   = cfg.enhanced ? db_ff : 8'd0;
                              st_in    = ST_TX_FETCH;
                           end else begin
                              phase_in = PH_DATA;
                              st_in    = ST_ACCEPT;
                           end
                        end
                     end
                     PH_DATA: begin
                        if (byte_cnt_ff < live_len) begin
                           rb_we       = 1'b1;
                           byte_cnt_in = byte_cnt_ff + 1'b1;
                           st_in       = ST_ACCEPT;
                        end else begin
                           // checksum byte: sum the buffer first
                           len_in = live_len;
                           idx_in = '0;
                           sum_in = cfg.enhanced ? cur_pid_ff : 8'd0;
                           st_in  = ST_CK_FETCH;
                        end
                     end
                     PH_IDLE: begin
                        if (out_free) begin
                           emit        = 1'b1;
                           ev          = EV_STRAY;
                           byte_cnt_in = '0;
                           st_in       = ST_ACCEPT;
                        end
                     end
                  endcase
               end
            endcase
         end

         ST_READ_WAIT: begin
            if (out_free) begin
               emit  = 1'b1;
               ev    = EV_READ;
               sl    = si_ff;
               ob    = st_rdata;
               st_in = ST_ACCEPT;
            end
         end

         ST_TX_FETCH: begin
            if (idx_ff < len_ff) begin
               st_re    = 1'b1;
               st_raddr = st_addr(cur_slot_ff, idx_ff);
               st_in    = ST_TX_SEND;
            end else begin
               st_in = ST_TX_CHECK;
            end
         end

         ST_TX_SEND: begin
            if (out_free) begin
               emit   = 1'b1;
               ev     = EV_TX;
               sl     = cur_slot_ff;
               ob     = st_rdata;
               lst    = 1'b0;
               sum_in = oc_add(sum_ff, st_rdata);
               idx_in = idx_ff + 1'b1;
               st_in  = ST_TX_FETCH;
            end
         end

         ST_TX_CHECK: begin
            if (out_free) begin
               emit  = 1'b1;
               ev    = EV_TX;
               sl    = cur_slot_ff;
               ob    = ~sum_ff;
               st_in = ST_ACCEPT;
            end
         end

         ST_CK_FETCH: begin
            if (idx_ff < len_ff) begin
               rb_re = 1'b1;
               st_in = ST_CK_ADD;
            end else if (db_ff == ~sum_ff) begin
               idx_in = '0;
               st_in  = ST_COPY_FETCH;
            end else if (out_free) begin
               emit        = 1'b1;
               ev          = EV_CHECKSUM;
               sl          = cur_slot_ff;
               phase_in    = PH_IDLE;
               byte_cnt_in = '0;
               st_in       = ST_ACCEPT;
            end
         end

         ST_CK_ADD: begin
            sum_in = oc_add(sum_ff, rb_rdata);
            idx_in = idx_ff + 1'b1;
            st_in  = ST_CK_FETCH;
         end

         ST_COPY_FETCH: begin
            if (idx_ff < len_ff) begin
               rb_re = 1'b1;
               st_in = ST_COPY_WRITE;
            end else if (out_free) begin
               emit        = 1'b1;
               ev          = EV_RXOK;
               sl          = cur_slot_ff;
               phase_in    = PH_IDLE;
               byte_cnt_in = '0;
               st_in       = ST_ACCEPT;
            end
         end

         ST_COPY_WRITE: begin
            st_we    = 1'b1;
            st_waddr = st_addr(cur_slot_ff, idx_ff);
            st_wdata = rb_rdata;
            idx_in   = idx_ff + 1'b1;
            st_in    = ST_COPY_FETCH;
         end

         default: st_in = ST_ACCEPT;
      endcase

      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_event_in = ev;
         rsp_slot_in  = sl;
         rsp_byte_in  = ob;
         rsp_last_in  = lst;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_ACCEPT;
         phase_ff     <= PH_IDLE;
         byte_cnt_ff  <= '0;
         idx_ff       <= '0;
         len_ff       <= '0;
         cur_slot_ff  <= '0;
         cur_pid_ff   <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         phase_ff     <= phase_in;
         byte_cnt_ff  <= byte_cnt_in;
         idx_ff       <= idx_in;
         len_ff       <= len_in;
         cur_slot_ff  <= cur_slot_in;
         cur_pid_ff   <= cur_pid_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      db_ff        <= db_in;
      si_ff        <= si_in;
      bi_ff        <= bi_in;
      rsp_event_ff <= rsp_event_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_event = rsp_event_ff;
   assign rsp_slot  = rsp_slot_ff;
   assign rsp_byte  = rsp_byte_ff;
   assign rsp_last  = rsp_last_ff;

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free)
      else $error("result loaded over an untaken result");

   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> st_ff == ST_DECODE)
      else $error("accepted transfer not decoded");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      byte_cnt_ff <= LEN_W'(MAX_LEN) && len_ff <= LEN_W'(MAX_LEN))
      else $error("byte count or length beyond buffer");

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= len_ff)
      else $error("pass index beyond length");

   a_rxok_phase: assert property (@(posedge clock) disable iff (reset)
      emit && ev == EV_RXOK |-> phase_ff == PH_DATA && db_ff == ~sum_ff)
      else $error("frame accepted outside a good receive frame");
`endif

endmodule

`default_nettype wire

### hw/rtl/lin_slave_frame_engine_top.sv
// Top level of the LIN slave frame engine: stream ports, configuration port.
// Depends on lsfe_pkg, lsfe_cfg, lsfe_ctrl (and lsfe_ram through lsfe_ctrl).
`timescale 1ns / 1ps
`default_nettype none

// LIN slave frame engine.
// req_ carries one event per transfer: a break, a received bus byte, or a host
// write or read of slot data. rsp_ carries the resulting events (transmit
// bytes, read data, frame status and errors); rsp_tlast marks the final result
// of one input transfer. csr_ writes the checksum mode, the break mode and the
// four slot table entries; write them only while the engine is quiet.
// Sequencing: a transfer is taken, then decoded in the next cycle; a new
// transfer is taken only once the last is done. A host read adds a
// registered read of the slot store. A transmit PID fetches and sends each
// data byte of the slot in turn, then the checksum. The checksum byte of a
// receive frame sweeps the receive buffer once to sum and once to copy
// into the slot store (a bad checksum skips the copy).
// A stalled rsp_tready holds the result register; the engine keeps working
// and accepts a further transfer as long as it needs no new result slot.
// Reset clears the header state and configuration; the data memories are not
// cleared and read as undefined until written.
module lin_slave_frame_engine_top #(
   parameter int NUM_SLOTS = lsfe_pkg::NUM_SLOTS_DEF,
   parameter int MAX_LEN   = lsfe_pkg::MAX_LEN_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // data_byte [7:0], slot_index [9:8], byte_index [12:10], zero [15:13]
   input  wire logic [15:0]                      req_tdata,
   // kind [1:0]
   input  wire logic [1:0]                       req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // slot [1:0], out_byte [9:2], zero [15:10]
   output logic [15:0]                           rsp_tdata,
   // event_res [3:0]
   output logic [3:0]                            rsp_tuser,
   output logic                                  rsp_tlast,
   input  wire logic                             csr_we,
   input  wire logic [lsfe_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [lsfe_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import lsfe_pkg::*;

   lsfe_cfg_type     cfg;
   lsfe_lookup_type  lookup;
   logic [LEN_W-1:0] live_len;
   logic [5:0]       lookup_id;
   logic [1:0]       cur_slot;
   lsfe_event_type   rsp_event;
   logic [1:0]       rsp_slot;
   logic [7:0]       rsp_byte;

   // register file and slot table match
   lsfe_cfg #(.NUM_SLOTS(NUM_SLOTS), .MAX_LEN(MAX_LEN)) u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .lookup_id (lookup_id),
      .cur_slot  (cur_slot),
      .cfg       (cfg),
      .lookup    (lookup),
      .live_len  (live_len)
   );

   // sequencer with slot store and receive buffer
   lsfe_ctrl #(.NUM_SLOTS(NUM_SLOTS), .MAX_LEN(MAX_LEN)) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_tvalid),
      .req_ready      (req_tready),
      .req_kind       (lsfe_kind_type'(req_tuser)),
      .req_data_byte  (req_tdata[7:0]),
      .req_slot_index (req_tdata[9:8]),
      .req_byte_index (req_tdata[12:10]),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_event      (rsp_event),
      .rsp_slot       (rsp_slot),
      .rsp_byte       (rsp_byte),
      .rsp_last       (rsp_tlast),
      .cfg            (cfg),
      .lookup         (lookup),
      .live_len       (live_len),
      .lookup_id      (lookup_id),
      .cur_slot       (cur_slot)
   );

   // pack the result transfer, lowest field first
   assign rsp_tdata = {6'd0, rsp_byte, rsp_slot};
   assign rsp_tuser = rsp_event;

endmodule

`default_nettype wire

### verif/lsfe_frame_checker.sv
// Frame checker of the LIN slave frame engine: follows req_ and csr_ transfers,
// predicts every rsp_ transfer and compares it. Also holds lsfe_tb_pkg.
// Depends on lsfe_pkg from the RTL.
`timescale 1ns / 1ps

package lsfe_tb_pkg;
   import lsfe_pkg::*;

   // Protected identifier: parity bits 6 and 7 on top of the 6-bit ID
   function automatic logic [7:0] lin_pid(input logic [5:0] id);
      return {~^(id & 6'b111010), ^(id & 6'b010111), id};
   endfunction

   // Inverted sum with end-around carry over the first n bytes of body
   function automatic logic [7:0] frame_sum(input logic [7:0] seed, input logic [63:0] body,
                                            input int n);
      logic [8:0] acc;
      acc = {1'b0, seed};
      for (int i = 0; i < n; i++) begin
         acc = acc + {1'b0, body[8*i +: 8]};
         if (acc > 9'd255) acc = acc - 9'd255;
      end
      return ~acc[7:0];
   endfunction

   function automatic int sat_len(input logic [3:0] len);
      return (len > MAX_LEN_DEF) ? MAX_LEN_DEF : int'(len);
   endfunction

   // Lowest enabled slot carrying the ID, or -1
   function automatic int find_slot(input logic [47:0] tab, input logic [5:0] id);
      lsfe_slot_entry_type e;
      for (int s = 0; s < NUM_SLOTS_DEF; s++) begin
         e = tab[12*s +: 12];
         if (e.enabled && e.id == id) return s;
      end
      return -1;
   endfunction
endpackage

module lsfe_frame_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [15:0] req_tdata,
   input  wire logic [1:0]  req_tuser,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [15:0] rsp_tdata,
   input  wire logic [3:0]  rsp_tuser,
   input  wire logic        rsp_tlast,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [11:0] csr_wdata,
   output int               mismatches,
   output int               outstanding
);
   import lsfe_pkg::*;
   import lsfe_tb_pkg::*;

   typedef struct packed {
      lsfe_event_type ev;
      logic [1:0]     slot;
      logic [7:0]     data;
      logic           last;
   } lin_event_type;

   lin_event_type  due_events[$];
   int             fail_n = 0;

   logic           enhanced;
   logic           brk_sync;
   logic [47:0]    slot_tab;
   lsfe_phase_type phase;
   int             nrx;
   logic [1:0]     cur_slot;
   logic [7:0]     cur_pid;
   logic [63:0]    rx_buf;
   logic [7:0]     slot_store [32];

   task automatic post(input lsfe_event_type ev, input logic [1:0] sl, input logic [7:0] b,
                       input logic last);
      lin_event_type e;
      e.ev   = ev;
      e.slot = sl;
      e.data = b;
      e.last = last;
      due_events.push_back(e);
   endtask

   task automatic engine_step(input lsfe_kind_type kind, input logic [7:0] db,
                              input logic [1:0] si, input logic [2:0] bi);
      int                  hit;
      int                  n;
      logic [63:0]         txd;
      lsfe_slot_entry_type e;
      txd = '0;
      case (kind)
         KIND_BREAK: begin
            if (phase != PH_IDLE) post(EV_BREAK, cur_slot, 8'h00, 1'b1);
            phase = brk_sync ? PH_PID : PH_SYNC;
            nrx   = 0;
         end
         KIND_HOST_WR: slot_store[{si, bi}] = db;
         KIND_HOST_RD: post(EV_READ, si, slot_store[{si, bi}], 1'b1);
         default: begin
            case (phase)
               PH_SYNC: begin
                  if (db != SYNC_BYTE) begin
                     post(EV_SYNC, 2'd0, 8'h00, 1'b1);
                     phase = PH_IDLE;
                     nrx   = 0;
                  end else begin
                     phase = PH_PID;
                  end
               end
               PH_PID: begin
                  phase = PH_IDLE;
                  nrx   = 0;
                  hit   = find_slot(slot_tab, db[5:0]);
                  if (lin_pid(db[5:0]) != db) begin
                     post(EV_PARITY, 2'd0, 8'h00, 1'b1);
                  end else if (hit < 0) begin
                     post(EV_UNKNOWN, 2'd0, 8'h00, 1'b1);
                  end else begin
                     cur_slot = hit[1:0];
                     cur_pid  = db;
                     e        = slot_tab[12*hit +: 12];
                     if (e.transmit) begin
                        n = sat_len(e.len);
                        for (int i = 0; i < n; i++) begin
                           txd[8*i +: 8] = slot_store[{hit[1:0], 3'(i)}];
                           post(EV_TX, hit[1:0], txd[8*i +: 8], 1'b0);
                        end
                        post(EV_TX, hit[1:0], frame_sum(enhanced ? db : 8'h00, txd, n), 1'b1);
                     end else begin
                        phase = PH_DATA;
                     end
                  end
               end
               PH_DATA: begin
                  e = slot_tab[12*cur_slot +: 12];
                  n = sat_len(e.len);
                  if (nrx < n) begin
                     rx_buf[8*nrx +: 8] = db;
                     nrx++;
                  end else begin
                     if (db == frame_sum(enhanced ? cur_pid : 8'h00, rx_buf, n)) begin
                        for (int i = 0; i < n; i++)
                           slot_store[{cur_slot, 3'(i)}] = rx_buf[8*i +: 8];
                        post(EV_RXOK, cur_slot, 8'h00, 1'b1);
                     end else begin
                        post(EV_CHECKSUM, cur_slot, 8'h00, 1'b1);
                     end
                     phase = PH_IDLE;
                     nrx   = 0;
                  end
               end
               default: begin
                  post(EV_STRAY, 2'd0, 8'h00, 1'b1);
                  phase = PH_IDLE;
                  nrx   = 0;
               end
            endcase
         end
      endcase
   endtask

   task automatic check_result();
      lin_event_type want;
      if (due_events.size() == 0) begin
         fail_n++;
         $display("%0t: unexpected result: expected none, actual ev %0d slot %0d byte %02h last %0b",
                  $time, rsp_tuser, rsp_tdata[1:0], rsp_tdata[9:2], rsp_tlast);
      end else begin
         want = due_events.pop_front();
         if (rsp_tuser !== want.ev || rsp_tdata[1:0] !== want.slot ||
             rsp_tdata[9:2] !== want.data || rsp_tdata[15:10] !== 6'd0 ||
             rsp_tlast !== want.last) begin
            fail_n++;
            $display("%0t: result mismatch: expected ev %0d slot %0d byte %02h last %0b pad 00",
                     $time, want.ev, want.slot, want.data, want.last);
            $display("%0t:                  actual   ev %0d slot %0d byte %02h last %0b pad %02h",
                     $time, rsp_tuser, rsp_tdata[1:0], rsp_tdata[9:2], rsp_tlast,
                     rsp_tdata[15:10]);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         enhanced = 1'b1;
         brk_sync = 1'b0;
         slot_tab = '0;
         phase    = PH_IDLE;
         nrx      = 0;
         cur_slot = 2'd0;
         cur_pid  = 8'h00;
         rx_buf   = '0;
         due_events.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) check_result();
         if (csr_we) begin
            case (lsfe_csr_type'(csr_index))
               CSR_CHECKSUM_ENH: enhanced         = csr_wdata[0];
               CSR_BREAK_SYNC:   brk_sync         = csr_wdata[0];
               CSR_SLOT_0:       slot_tab[11:0]   = csr_wdata;
               CSR_SLOT_1:       slot_tab[23:12]  = csr_wdata;
               CSR_SLOT_2:       slot_tab[35:24]  = csr_wdata;
               CSR_SLOT_3:       slot_tab[47:36]  = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            engine_step(lsfe_kind_type'(req_tuser), req_tdata[7:0], req_tdata[9:8],
                        req_tdata[12:10]);
      end
      mismatches  <= fail_n;
      outstanding <= due_events.size();
   end
endmodule

### verif/tb_lin_slave_frame_engine_top.sv
// Testbench top of the LIN slave frame engine: clock, reset, stimulus and verdict.
// Depends on lsfe_pkg, lin_slave_frame_engine_top and lsfe_frame_checker (with lsfe_tb_pkg).
`timescale 1ns / 1ps

module tb_lin_slave_frame_engine_top;
   import lsfe_pkg::*;
   import lsfe_tb_pkg::*;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [15:0]           req_tdata;
   logic [1:0]            req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [15:0]           rsp_tdata;
   logic [3:0]            rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    mismatches;
   int                    outstanding;

   // Idling knobs; the percentages change only just after a rising edge
   int                    send_idle_pct = 0;
   int                    stall_pct = 0;
   logic                  hold_req = 1'b0;
   int                    hold_left = 0;

   // Mirror of what has been written to the configuration port
   logic                  enh_mode;
   logic                  brk_mode;
   logic [47:0]           slot_tab;
   int                    sent = 0;

   lin_slave_frame_engine_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   lsfe_frame_checker frame_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard limit, many times the slowest legal run
   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // Result side: stall at random, or hold off for a long stretch on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_left = 300;
            hold_req  = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // Offer one transfer, idling first at random; return at the accepting edge
   task automatic offer(input lsfe_kind_type kind, input logic [7:0] db, input logic [1:0] si,
                        input logic [2:0] bi);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {3'b000, bi, si, db};
      do @(posedge clock); while (!req_tready);
      sent++;
   endtask

   // Bus byte; the host fields carry noise since the engine ignores them
   task automatic bus_byte(input logic [7:0] db);
      offer(KIND_BYTE, db, 2'($urandom), 3'($urandom));
   endtask

   task automatic bus_break();
      offer(KIND_BREAK, 8'($urandom), 2'($urandom), 3'($urandom));
   endtask

   // Drop valid, drain every expected result, then let silent work finish
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_reg(input lsfe_csr_type idx, input logic [11:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic configure(input logic enh, input logic brk, input logic [47:0] tab);
      settle();
      enh_mode = enh;
      brk_mode = brk;
      slot_tab = tab;
      write_reg(CSR_CHECKSUM_ENH, {11'd0, enh});
      write_reg(CSR_BREAK_SYNC, {11'd0, brk});
      write_reg(CSR_SLOT_0, tab[11:0]);
      write_reg(CSR_SLOT_1, tab[23:12]);
      write_reg(CSR_SLOT_2, tab[35:24]);
      write_reg(CSR_SLOT_3, tab[47:36]);
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      @(posedge clock);
      send_idle_pct = send_pct;
      stall_pct     = recv_pct;
   endtask

   task automatic run_header(input logic [7:0] pid);
      bus_break();
      if (!brk_mode) bus_byte(SYNC_BYTE);
      bus_byte(pid);
   endtask

   // Full frame for the ID; a receive slot gets its data and a checksum,
   // spoilt or cut off by a break on request
   task automatic run_frame(input logic [5:0] id, input bit bad_sum, input bit cut);
      int                  hit;
      int                  n;
      int                  cut_at;
      logic [63:0]         body;
      logic [7:0]          sum;
      lsfe_slot_entry_type e;
      run_header(lin_pid(id));
      hit = find_slot(slot_tab, id);
      if (hit < 0) return;
      e = slot_tab[12*hit +: 12];
      if (e.transmit) return;
      n      = sat_len(e.len);
      cut_at = cut ? $urandom_range(n) : n + 1;
      body   = '0;
      for (int i = 0; i < n; i++) begin
         if (i == cut_at) begin
            bus_break();
            return;
         end
         body[8*i +: 8] = 8'($urandom);
         bus_byte(body[8*i +: 8]);
      end
      if (cut_at == n) begin
         bus_break();
         return;
      end
      sum = frame_sum(enh_mode ? lin_pid(id) : 8'h00, body, n);
      if (bad_sum) sum = sum ^ 8'($urandom_range(255, 1));
      bus_byte(sum);
   endtask

   function automatic logic [11:0] random_entry();
      lsfe_slot_entry_type e;
      e.enabled  = ($urandom_range(99) < 85);
      e.transmit = 1'($urandom);
      e.len      = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8));
      e.id       = 6'($urandom);
      return e;
   endfunction

   // Mostly an ID from the table, so that frames get past the lookup
   function automatic logic [5:0] pick_id();
      lsfe_slot_entry_type e;
      e = slot_tab[12*$urandom_range(3) +: 12];
      return ($urandom_range(99) < 75) ? e.id : 6'($urandom);
   endfunction

   task automatic random_traffic(input int count);
      int         stop_at;
      int         pick;
      logic [7:0] db;
      stop_at = sent + count;
      while (sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 42) begin
            run_frame(pick_id(), $urandom_range(99) < 20, $urandom_range(99) < 8);
         end else if (pick < 50) begin
            // flip one parity bit
            run_header(lin_pid(pick_id()) ^ (8'h40 << $urandom_range(1)));
         end else if (pick < 56) begin
            db = 8'($urandom);
            if (db == SYNC_BYTE) db = 8'h00;
            bus_break();
            bus_byte(db);
         end else if (pick < 62) begin
            bus_byte(8'($urandom));
         end else if (pick < 78) begin
            offer(KIND_HOST_RD, 8'($urandom), 2'($urandom), 3'($urandom));
         end else if (pick < 92) begin
            offer(KIND_HOST_WR, 8'($urandom), 2'($urandom), 3'($urandom));
         end else begin
            bus_break();
         end
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      enh_mode   = 1'b1;
      brk_mode   = 1'b0;
      slot_tab   = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Fill the slot store first so that no read ever meets an unwritten byte
      for (int s = 0; s < NUM_SLOTS_DEF; s++)
         for (int b = 0; b < MAX_LEN_DEF; b++)
            offer(KIND_HOST_WR, 8'($urandom), 2'(s), 3'(b));

      // Directed: tx id 10h len 8, rx id 21h len 8, tx id 3Fh len 0, rx id 00h len 0
      configure(1'b1, 1'b0, {12'h800, 12'hC3F, 12'hA21, 12'hE10});
      bus_byte(8'hFF);                     // stray byte in idle
      bus_break();                         // break in idle, silent
      bus_break();                         // break mid-header
      bus_byte(8'h00);                     // wrong sync byte
      run_header(lin_pid(6'h10) ^ 8'h80);  // parity mismatch
      run_header(lin_pid(6'h2A));          // ID in no slot
      run_frame(6'h10, 1'b0, 1'b0);        // transmit, full length
      run_frame(6'h21, 1'b0, 1'b0);        // receive, full length, good checksum
      offer(KIND_HOST_RD, 8'h00, 2'd1, 3'd7);
      run_frame(6'h3F, 1'b0, 1'b0);        // transmit, checksum only
      run_frame(6'h00, 1'b1, 1'b0);        // receive, checksum only, spoilt

      // Random phases; the first and last use extreme tables
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: configure(1'b0, 1'b0, {12'($urandom), random_entry(), 12'h000, 12'hFFF});
            5: configure(1'b1, 1'b1, {12'hBFF, 12'hFFF, 12'h7C0, random_entry()});
            4: configure(1'($urandom), 1'($urandom),
                         {random_entry(), random_entry(), random_entry(),
                          {2'b11, 4'd8, 6'($urandom)}});
            default: configure(1'($urandom), 1'($urandom),
                               {random_entry(), random_entry(), random_entry(),
                                random_entry()});
         endcase
         case (ph)
            1:       set_idling(73, 0);
            2:       set_idling(0, 73);
            3, 5:    set_idling(27, 27);
            default: set_idling(0, 0);
         endcase
         // Hold the result side off so that the engine backs up into req_
         if (ph == 4) hold_req = 1'b1;
         random_traffic(15);
      end

      settle();
      if (mismatches == 0 && outstanding == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end
endmodule
